FILE: hw/rtl/unicycle_waypoint_tracking_law_core_macros.svh
// Assertion macros shared by the tracking law RTL.
`ifndef UNICYCLE_WAYPOINT_TRACKING_LAW_CORE_MACROS_SVH
`define UNICYCLE_WAYPOINT_TRACKING_LAW_CORE_MACROS_SVH

// Property that holds on every clock outside reset.
`define UWTL_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition in the cycle after a trigger.
`define UWTL_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/uwtl_pkg.sv
// Types, constants and tables of the tracking law core.
package uwtl_pkg;

	localparam logic signed [35:0] PI30      = 36'sd3373259426;
	localparam logic signed [35:0] HALF_PI30 = 36'sd1686629713;
	localparam logic signed [35:0] GAIN30    = 36'sd652032874;
	localparam logic signed [17:0] ONE16     = 18'sd65536;

	localparam logic [2:0] REG_WAYPOINT_X    = 3'd0;
	localparam logic [2:0] REG_WAYPOINT_Y    = 3'd1;
	localparam logic [2:0] REG_REF_SPEED     = 3'd2;
	localparam logic [2:0] REG_REF_TURN_RATE = 3'd3;
	localparam logic [2:0] REG_LATERAL_GAIN  = 3'd4;
	localparam logic [2:0] REG_HEADING_GAIN  = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_DRAIN, ST_YAW_CHK, ST_LAUNCH, ST_CWAIT, ST_OUT
	} st_t;

	typedef enum logic [3:0] {
		MOP_XX, MOP_YY, MOP_ZZ, MOP_WW, MOP_XZ, MOP_WY, MOP_XY, MOP_WZ,
		MOP_DYC, MOP_DXS, MOP_K2V, MOP_K3V, MOP_LIN, MOP_LHI, MOP_LLO, MOP_K3S
	} mop_t;

	typedef enum logic [1:0] {
		JOB_YAW_ATAN, JOB_YAW_SC, JOB_BRG_ATAN, JOB_HERR_SC
	} job_t;

	typedef enum logic [2:0] {
		CS_IDLE, CS_FOLD, CS_NORM, CS_ITER, CS_POST
	} cst_t;

	typedef enum logic {
		CM_VECTOR, CM_ROTATE
	} cmode_t;

	typedef struct packed {
		logic               start;
		cmode_t             mode;
		logic signed [35:0] y;
		logic signed [35:0] x;
		logic signed [16:0] angle;
	} cordic_req_t;

	typedef struct packed {
		logic               idle;
		logic               done;
		logic signed [15:0] angle;
		logic signed [17:0] sin_v;
		logic signed [17:0] cos_v;
	} cordic_rsp_t;

	// atan(2^-i) in Q1.30
	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'd843314857;
			5'd1:  r = 32'd497837830;
			5'd2:  r = 32'd263043837;
			5'd3:  r = 32'd133525159;
			5'd4:  r = 32'd67021687;
			5'd5:  r = 32'd33543516;
			5'd6:  r = 32'd16775851;
			5'd7:  r = 32'd8388437;
			5'd8:  r = 32'd4194283;
			5'd9:  r = 32'd2097149;
			5'd10: r = 32'd1048576;
			5'd11: r = 32'd524288;
			5'd12: r = 32'd262144;
			5'd13: r = 32'd131072;
			5'd14: r = 32'd65536;
			5'd15: r = 32'd32768;
			5'd16: r = 32'd16384;
			5'd17: r = 32'd8192;
			5'd18: r = 32'd4096;
			5'd19: r = 32'd2048;
			5'd20: r = 32'd1024;
			5'd21: r = 32'd512;
			5'd22: r = 32'd256;
			5'd23: r = 32'd128;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/uwtl_ifs.sv
// Handshake interfaces for the config, pose and command channels.
interface uwtl_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  addr;
	logic [31:0] data;
	modport source(output valid, addr, data, input ready);
	modport sink(input valid, addr, data, output ready);
endinterface

interface uwtl_pose_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] robot_x;
	logic signed [31:0] robot_y;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;
	logic signed [15:0] quat_w;
	modport source(output valid, robot_x, robot_y, quat_x, quat_y, quat_z, quat_w,
		input ready);
	modport sink(input valid, robot_x, robot_y, quat_x, quat_y, quat_z, quat_w,
		output ready);
endinterface

interface uwtl_cmd_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] linear_cmd;
	logic signed [31:0] angular_cmd;
	logic signed [16:0] heading_error;
	modport source(output valid, linear_cmd, angular_cmd, heading_error, input ready);
	modport sink(input valid, linear_cmd, angular_cmd, heading_error, output ready);
endinterface

FILE: hw/rtl/uwtl_cordic.sv
// Iterative CORDIC: atan2 in vectoring mode, sin/cos in rotation mode.
module uwtl_cordic import uwtl_pkg::*; #(
	parameter int CORDIC_ITERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cordic_req_t req,
	output cordic_rsp_t rsp
);

	localparam int IW = $clog2(CORDIC_ITERS);
	localparam logic [IW-1:0] LAST = IW'(CORDIC_ITERS - 1);

	cst_t               cst_q, cst_d;
	cmode_t             mode_q;
	logic               yneg_q, xneg_q, flip_q, done_q;
	logic signed [35:0] cx_q, cy_q, z_q;
	logic [IW-1:0]      iter_q;
	logic signed [15:0] ang_q;
	logic signed [17:0] sin_q, cos_q;

	logic signed [35:0] ax, ay, z_in, z_wr, dxs, dys, t, zc, zq;
	logic [35:0]        nv;
	logic               zero_in, turn, norm_ok;

	function automatic logic signed [17:0] round_clamp(input logic signed [35:0] v);
		logic signed [35:0] r;
		logic signed [17:0] o;
		r = (v + 36'sd8192) >>> 14;
		if (r > 36'(ONE16))
			o = ONE16;
		else if (r < -36'(ONE16))
			o = -ONE16;
		else
			o = r[17:0];
		return o;
	endfunction

	always_comb begin
		ax = req.x[35] ? -req.x : req.x;
		ay = req.y[35] ? -req.y : req.y;
		zero_in = (req.x == '0) && (req.y == '0);
		z_in = 36'(req.angle) <<< 17;
		if (z_in > PI30)
			z_wr = z_in - (PI30 <<< 1);
		else if (z_in < -PI30)
			z_wr = z_in + (PI30 <<< 1);
		else
			z_wr = z_in;
		nv = cx_q | cy_q;
		norm_ok = (nv[35:30] == '0) && nv[29];
		dxs = cy_q >>> iter_q;
		dys = cx_q >>> iter_q;
		t = signed'({4'b0, atan_lut(5'(iter_q))});
		turn = (mode_q == CM_VECTOR) ? cy_q[35] : !z_q[35];
		if (z_q[35])
			zc = '0;
		else if (z_q > HALF_PI30)
			zc = HALF_PI30;
		else
			zc = z_q;
		if (xneg_q)
			zc = PI30 - zc;
		zq = (zc + 36'sd65536) >>> 17;
	end

	always_comb begin
		cst_d = cst_q;
		unique case (cst_q)
			CS_IDLE: begin
				if (req.start) begin
					if (req.mode == CM_ROTATE)
						cst_d = CS_FOLD;
					else if (!zero_in)
						cst_d = CS_NORM;
				end
			end
			CS_FOLD: cst_d = CS_ITER;
			CS_NORM: if (norm_ok) cst_d = CS_ITER;
			CS_ITER: if (iter_q == LAST) cst_d = CS_POST;
			CS_POST: cst_d = CS_IDLE;
			default: cst_d = CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cst_q  <= CS_IDLE;
			done_q <= 1'b0;
		end else begin
			cst_q  <= cst_d;
			done_q <= (cst_q == CS_POST) ||
				((cst_q == CS_IDLE) && req.start && (req.mode == CM_VECTOR) && zero_in);
		end
	end

	always_ff @(posedge clk) begin
		case (cst_q)
			CS_IDLE: begin
				if (req.start) begin
					mode_q <= req.mode;
					flip_q <= 1'b0;
					iter_q <= '0;
					if (req.mode == CM_VECTOR) begin
						yneg_q <= req.y[35];
						xneg_q <= req.x[35];
						cx_q   <= ax;
						cy_q   <= ay;
						z_q    <= '0;
						ang_q  <= '0;
					end else begin
						cx_q <= GAIN30;
						cy_q <= '0;
						z_q  <= z_wr;
					end
				end
			end
			CS_FOLD: begin
				if (z_q > HALF_PI30) begin
					z_q    <= PI30 - z_q;
					flip_q <= 1'b1;
				end else if (z_q < -HALF_PI30) begin
					z_q    <= -PI30 - z_q;
					flip_q <= 1'b1;
				end
			end
			CS_NORM: begin
				if (nv[35:30] != '0) begin
					cx_q <= cx_q >>> 1;
					cy_q <= cy_q >>> 1;
				end else if (nv[35:21] == '0) begin
					cx_q <= cx_q <<< 8;
					cy_q <= cy_q <<< 8;
				end else if (!nv[29]) begin
					cx_q <= cx_q <<< 1;
					cy_q <= cy_q <<< 1;
				end
			end
			CS_ITER: begin
				if (turn) begin
					cx_q <= cx_q - dxs;
					cy_q <= cy_q + dys;
					z_q  <= z_q - t;
				end else begin
					cx_q <= cx_q + dxs;
					cy_q <= cy_q - dys;
					z_q  <= z_q + t;
				end
				iter_q <= iter_q + 1'b1;
			end
			CS_POST: begin
				if (mode_q == CM_VECTOR)
					ang_q <= yneg_q ? -zq[15:0] : zq[15:0];
				else begin
					sin_q <= round_clamp(cy_q);
					cos_q <= flip_q ? -round_clamp(cx_q) : round_clamp(cx_q);
				end
			end
			default: ;
		endcase
	end

	assign rsp.idle  = (cst_q == CS_IDLE);
	assign rsp.done  = done_q;
	assign rsp.angle = ang_q;
	assign rsp.sin_v = sin_q;
	assign rsp.cos_v = cos_q;

endmodule

FILE: hw/rtl/unicycle_waypoint_tracking_law_core.sv
// Top level of the unicycle waypoint tracking law core.
//
//  channel  dir   handshake     beat
//  cfg      in    valid/ready   addr, data (register write, always ready)
//  pose     in    valid/ready   robot_x, robot_y, quat_x..quat_w
//  cmd      out   valid/ready   linear_cmd, angular_cmd, heading_error
//
// One pose takes 16 products through the one 35x18 multiplier and three or four
// CORDIC passes (yaw atan2 skipped at the pitch singularity, a zero bearing
// vector skipping normalize and iterations). pose.ready is high only when idle.
// A result waits in the output register while cmd stalls; the next pose is
// taken once it is loaded. Reset restores config defaults and clears the bearing.
`include "unicycle_waypoint_tracking_law_core_macros.svh"
module unicycle_waypoint_tracking_law_core import uwtl_pkg::*; #(
	parameter int CORDIC_ITERS = 16
) (
	input logic         clk,
	input logic         arst_n,
	uwtl_cfg_if.sink    cfg,
	uwtl_pose_if.sink   pose,
	uwtl_cmd_if.source  cmd
);

	logic signed [31:0] wx_q, wy_q;
	logic [15:0]        v_q, w_q, k2_q, k3_q;

	st_t  st_q, st_d;
	job_t job_q;
	mop_t mop_q, mop_s1;
	logic acc_en_s1;

	logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
	logic signed [32:0] dx_q, dy_q;
	logic signed [35:0] d_q, s_q, g_q, yn_q;
	logic signed [52:0] prod_s1, lacc_q;
	logic signed [15:0] yaw_q, prev_q;
	logic signed [16:0] herr_q;
	logic signed [17:0] sy_q, cy_q, se_q, ce_q;
	logic [31:0]        k2v_q, k3v_q;
	logic signed [31:0] lin_q;
	logic signed [55:0] aacc_q;

	logic signed [31:0] out_lin_q, out_ang_q;
	logic signed [16:0] out_herr_q;
	logic               out_valid_q;

	logic signed [34:0] mul_a, lat;
	logic signed [17:0] mul_b;
	logic signed [52:0] prod_c;
	logic signed [35:0] g2, g2_mag, yat_y, yat_x;
	logic signed [31:0] ang_sat;
	logic               sing, accept, load;

	cordic_req_t creq;
	cordic_rsp_t crsp;

	uwtl_cordic #(.CORDIC_ITERS(CORDIC_ITERS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.rsp    (crsp)
	);

	assign cfg.ready = 1'b1;
	assign accept = pose.valid && pose.ready;
	assign load = (st_q == ST_OUT) && (!out_valid_q || cmd.ready);

	always_comb begin
		lat = signed'(lacc_q[50:16]);
		mul_a = '0;
		mul_b = '0;
		case (mop_q)
			MOP_XX:  begin mul_a = 35'(qx_q); mul_b = 18'(qx_q); end
			MOP_YY:  begin mul_a = 35'(qy_q); mul_b = 18'(qy_q); end
			MOP_ZZ:  begin mul_a = 35'(qz_q); mul_b = 18'(qz_q); end
			MOP_WW:  begin mul_a = 35'(qw_q); mul_b = 18'(qw_q); end
			MOP_XZ:  begin mul_a = 35'(qx_q); mul_b = 18'(qz_q); end
			MOP_WY:  begin mul_a = 35'(qw_q); mul_b = 18'(qy_q); end
			MOP_XY:  begin mul_a = 35'(qx_q); mul_b = 18'(qy_q); end
			MOP_WZ:  begin mul_a = 35'(qw_q); mul_b = 18'(qz_q); end
			MOP_DYC: begin mul_a = 35'(dy_q); mul_b = cy_q; end
			MOP_DXS: begin mul_a = 35'(dx_q); mul_b = sy_q; end
			MOP_K2V: begin mul_a = signed'(35'(k2_q)); mul_b = signed'(18'(v_q)); end
			MOP_K3V: begin mul_a = signed'(35'(k3_q)); mul_b = signed'(18'(v_q)); end
			MOP_LIN: begin mul_a = 35'(ce_q); mul_b = signed'(18'(v_q)); end
			MOP_LHI: begin mul_a = lat; mul_b = signed'(18'(k2v_q[31:16])); end
			MOP_LLO: begin mul_a = lat; mul_b = signed'(18'(k2v_q[15:0])); end
			MOP_K3S: begin mul_a = signed'(35'(k3v_q)); mul_b = se_q; end
			default: ;
		endcase
		prod_c = mul_a * mul_b;

		g2 = g_q <<< 1;
		g2_mag = g2[35] ? -g2 : g2;
		sing = (g2_mag >= d_q);
		yat_y = yn_q <<< 1;
		yat_x = d_q - (s_q <<< 1);

		if (aacc_q > 56'sd2147483647)
			ang_sat = 32'sh7fffffff;
		else if (aacc_q < -56'sd2147483648)
			ang_sat = 32'sh80000000;
		else
			ang_sat = aacc_q[31:0];

		creq.start = (st_q == ST_LAUNCH);
		creq.mode = ((job_q == JOB_YAW_ATAN) || (job_q == JOB_BRG_ATAN)) ?
			CM_VECTOR : CM_ROTATE;
		creq.y = (job_q == JOB_YAW_ATAN) ? yat_y : 36'(dy_q);
		creq.x = (job_q == JOB_YAW_ATAN) ? yat_x : 36'(dx_q);
		creq.angle = (job_q == JOB_YAW_SC) ? 17'(yaw_q) : herr_q;
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (pose.valid) st_d = ST_MUL;
			ST_MUL: begin
				if ((mop_q == MOP_WZ) || (mop_q == MOP_DXS) || (mop_q == MOP_K3S))
					st_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (mop_s1 == MOP_K3S)
					st_d = ST_OUT;
				else if (mop_s1 == MOP_DXS)
					st_d = ST_LAUNCH;
				else
					st_d = ST_YAW_CHK;
			end
			ST_YAW_CHK: st_d = ST_LAUNCH;
			ST_LAUNCH: st_d = ST_CWAIT;
			ST_CWAIT: begin
				if (crsp.done) begin
					if ((job_q == JOB_YAW_ATAN) || (job_q == JOB_BRG_ATAN))
						st_d = ST_LAUNCH;
					else
						st_d = ST_MUL;
				end
			end
			ST_OUT: if (load) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
		pose.ready = (st_q == ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			job_q       <= JOB_YAW_ATAN;
			acc_en_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			prev_q      <= '0;
			wx_q        <= '0;
			wy_q        <= '0;
			v_q         <= 16'd512;
			w_q         <= 16'd512;
			k2_q        <= 16'd512;
			k3_q        <= 16'd512;
		end else begin
			st_q      <= st_d;
			acc_en_s1 <= (st_q == ST_MUL);
			if (load)
				out_valid_q <= 1'b1;
			else if (cmd.ready)
				out_valid_q <= 1'b0;
			if (st_q == ST_YAW_CHK)
				job_q <= sing ? JOB_YAW_SC : JOB_YAW_ATAN;
			else if ((st_q == ST_DRAIN) && (mop_s1 == MOP_DXS))
				job_q <= JOB_BRG_ATAN;
			else if ((st_q == ST_CWAIT) && crsp.done) begin
				if (job_q == JOB_YAW_ATAN)
					job_q <= JOB_YAW_SC;
				else if (job_q == JOB_BRG_ATAN)
					job_q <= JOB_HERR_SC;
			end
			if ((st_q == ST_CWAIT) && crsp.done && (job_q == JOB_BRG_ATAN))
				prev_q <= crsp.angle;
			if (cfg.valid) begin
				unique case (cfg.addr)
					REG_WAYPOINT_X:    wx_q <= signed'(cfg.data);
					REG_WAYPOINT_Y:    wy_q <= signed'(cfg.data);
					REG_REF_SPEED:     v_q  <= cfg.data[15:0];
					REG_REF_TURN_RATE: w_q  <= cfg.data[15:0];
					REG_LATERAL_GAIN:  k2_q <= cfg.data[15:0];
					REG_HEADING_GAIN:  k3_q <= cfg.data[15:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			qx_q   <= pose.quat_x;
			qy_q   <= pose.quat_y;
			qz_q   <= pose.quat_z;
			qw_q   <= pose.quat_w;
			dx_q   <= 33'(wx_q) - 33'(pose.robot_x);
			dy_q   <= 33'(wy_q) - 33'(pose.robot_y);
			d_q    <= '0;
			s_q    <= '0;
			g_q    <= '0;
			yn_q   <= '0;
			aacc_q <= signed'(56'({w_q, 8'h00}));
			mop_q  <= MOP_XX;
		end else if (st_q == ST_MUL)
			mop_q <= mop_t'(mop_q + 4'd1);

		prod_s1 <= prod_c;
		mop_s1  <= mop_q;

		if (acc_en_s1) begin
			case (mop_s1) inside
				MOP_XX, MOP_WW: d_q <= d_q + signed'(prod_s1[35:0]);
				MOP_YY, MOP_ZZ: begin
					d_q <= d_q + signed'(prod_s1[35:0]);
					s_q <= s_q + signed'(prod_s1[35:0]);
				end
				MOP_XZ: g_q <= g_q + signed'(prod_s1[35:0]);
				MOP_WY: g_q <= g_q - signed'(prod_s1[35:0]);
				MOP_XY, MOP_WZ: yn_q <= yn_q + signed'(prod_s1[35:0]);
				MOP_DYC: lacc_q <= prod_s1;
				MOP_DXS: lacc_q <= lacc_q - prod_s1;
				MOP_K2V: k2v_q <= prod_s1[31:0];
				MOP_K3V: k3v_q <= prod_s1[31:0];
				MOP_LIN: lin_q <= signed'(prod_s1[39:8]);
				MOP_LHI: aacc_q <= aacc_q + 56'(prod_s1);
				MOP_LLO, MOP_K3S: aacc_q <= aacc_q + 56'(prod_s1 >>> 16);
				default: ;
			endcase
		end

		if ((st_q == ST_YAW_CHK) && sing)
			yaw_q <= '0;
		if ((st_q == ST_DRAIN) && (mop_s1 == MOP_DXS))
			herr_q <= 17'(prev_q) - 17'(yaw_q);
		if ((st_q == ST_CWAIT) && crsp.done) begin
			case (job_q)
				JOB_YAW_ATAN: yaw_q <= crsp.angle;
				JOB_YAW_SC: begin
					sy_q <= crsp.sin_v;
					cy_q <= crsp.cos_v;
				end
				JOB_HERR_SC: begin
					se_q <= crsp.sin_v;
					ce_q <= crsp.cos_v;
				end
				default: ;
			endcase
		end

		if (load) begin
			out_lin_q  <= lin_q;
			out_ang_q  <= ang_sat;
			out_herr_q <= herr_q;
		end
	end

	assign cmd.valid         = out_valid_q;
	assign cmd.linear_cmd    = out_lin_q;
	assign cmd.angular_cmd   = out_ang_q;
	assign cmd.heading_error = out_herr_q;

	`UWTL_CHECK(a_start_when_idle, creq.start |-> crsp.idle, "CORDIC started while busy")
	`UWTL_CHECK(a_done_in_wait, crsp.done |-> (st_q == ST_CWAIT), "CORDIC done outside wait")
	`UWTL_NEXT(a_accept_to_mul, accept, st_q == ST_MUL, "accepted beat did not start products")

endmodule
